[hw/rtl/float_to_int8_quantizer_defines.svh]
// Assertion macros for the float to int8 quantizer
`ifndef FLOAT_TO_INT8_QUANTIZER_DEFINES_SVH
`define FLOAT_TO_INT8_QUANTIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define F2I_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define F2I_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef ASSERT_OFF
`define F2I_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define F2I_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hw/rtl/f2i_pkg.sv]
// ----------------------------------------------------------------------------
// f2i_pkg
// Types and constants shared by the quantizer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package f2i_pkg;
  localparam int unsigned FIELD_LANES = 4;
  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  typedef logic [31:0] fp32_t;
  typedef logic signed [7:0] q8_t;
  typedef logic [2:0] cnt_t;

  // per-lane product, kept after the multiplier register
  typedef struct packed {
    logic        nan;
    logic        sign;
    logic        zero;
    logic        big;     // infinite operand, saturates
    logic [9:0]  exp;     // biased, unbounded small
    logic [47:0] mant;    // raw 24x24 product
  } prod_t;

  // per-lane product as fixed point, kept in the align register
  typedef struct packed {
    logic        nan;
    logic        sign;
    logic        zero;
    logic        big;
    logic        ovf;     // |p| >= 2^41 or infinite, saturates
    logic        lost;    // nonzero bits below the fixed-point lsb
    logic [71:0] mfix;    // |p|, 28 fraction bits
  } algn_t;
endpackage
`default_nettype wire

[hw/rtl/f2i_if.sv]
// ----------------------------------------------------------------------------
// f2i_in_if / f2i_out_if / f2i_cfg_if
// Valid/ready channels of the quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
interface f2i_in_if;
  logic valid;
  logic ready;
  logic [31:0] lane_a, lane_b, lane_c, lane_d;
  logic [2:0] lane_count;
  modport source (output valid, lane_a, lane_b, lane_c, lane_d, lane_count, input ready);
  modport sink (input valid, lane_a, lane_b, lane_c, lane_d, lane_count, output ready);
endinterface

interface f2i_out_if;
  logic valid;
  logic ready;
  logic signed [7:0] byte_a, byte_b, byte_c, byte_d;
  logic [2:0] valid_count;
  modport source (output valid, byte_a, byte_b, byte_c, byte_d, valid_count, input ready);
  modport sink (input valid, byte_a, byte_b, byte_c, byte_d, valid_count, output ready);
endinterface

interface f2i_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/f2i_mul.sv]
// ----------------------------------------------------------------------------
// f2i_mul
// Lane multiplier stage: unpacks x and scale, one 24x24 multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module f2i_mul (
  input  wire logic          x,
  input  wire f2i_pkg::fp32_t xv,
  input  wire f2i_pkg::fp32_t sv,
  output f2i_pkg::prod_t     p
);
  import f2i_pkg::*;
  logic [7:0] ex, es;
  logic [23:0] mx, ms;
  logic xnan, snan, xinf, sinf, xz, sz;
  logic [9:0] esum;
  always_comb begin
    ex = xv[30:23];
    es = sv[30:23];
    mx = {ex != 8'd0, xv[22:0]};
    ms = {es != 8'd0, sv[22:0]};
    xnan = (ex == 8'hFF) && (xv[22:0] != 23'd0);
    snan = (es == 8'hFF) && (sv[22:0] != 23'd0);
    xinf = (ex == 8'hFF) && (xv[22:0] == 23'd0);
    sinf = (es == 8'hFF) && (sv[22:0] == 23'd0);
    xz = (xv[30:0] == 31'd0);
    sz = (sv[30:0] == 31'd0);
    // exponent of the product, value = mant * 2^(esum-254-46); denormal exp is 1
    esum = {2'b00, (ex == 8'd0) ? 8'd1 : ex} + {2'b00, (es == 8'd0) ? 8'd1 : es};
    p.sign = xv[31] ^ sv[31];
    p.nan = x & (xnan | snan | (xinf & sz) | (sinf & xz));
    p.zero = xz | sz;
    p.big = xinf | sinf;
    p.exp = esum;
    p.mant = mx * ms;
  end
endmodule
`default_nettype wire

[hw/rtl/f2i_round.sv]
// ----------------------------------------------------------------------------
// f2i_round
// Lane back end, two stages: rounds the product to single and aligns it to
// fixed point, then adds 0.5 with RNE, truncates and saturates to int8.
// ----------------------------------------------------------------------------
`default_nettype none
module f2i_round (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire f2i_pkg::prod_t p,
  output f2i_pkg::q8_t        q
);
  import f2i_pkg::*;
  // shift so that bit 0 of mfix is 2^-(FRAC)
  localparam int FRAC = 28;
  logic [5:0] lz;
  logic [47:0] nm;
  logic signed [11:0] e;        // unbiased exp of leading bit of nm
  logic [23:0] m24;
  logic g, st, lsb, up;
  logic [24:0] mr;
  logic signed [11:0] er;
  logic signed [12:0] rsh;
  algn_t a_nxt, a_r;
  logic signed [12:0] sh;
  logic [9:0] mag;              // |s| truncated, clamped
  logic [71:0] w, half, sum, rem;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) if (p.mant[i]) lz = 6'(47 - i);
    nm = p.mant << lz;
    // leading bit weight: 2^(exp - 254 + 1 - lz)
    e = 12'(signed'({2'b00, p.exp})) - 12'sd253 - 12'(signed'({6'd0, lz}));
    // round product to 24 bits; for small results single denormal range
    // never matters here since |p|<2^-126 gives 0 in the end anyway
    m24 = nm[47:24];
    g = nm[23];
    st = |nm[22:0];
    lsb = nm[24];
    up = g & (st | lsb);
    mr = {1'b0, m24} + 25'(up);
    er = e;
    if (mr[24]) begin
      mr = mr >> 1;
      er = e + 12'sd1;
    end
    // product as fixed point (only needed when < 2^41), place mr[23] at 2^er
    rsh = 13'sd23 - 13'(er) - 13'sd28;  // right shift of mr into mfix
    a_nxt.nan = p.nan;
    a_nxt.sign = p.sign;
    a_nxt.zero = p.zero;
    a_nxt.big = p.big;
    a_nxt.ovf = p.big || (er > 12'sd40);
    a_nxt.mfix = 72'd0;
    a_nxt.lost = 1'b0;
    if (er > 12'sd40) a_nxt.mfix = 72'd0;
    else if (rsh >= 0) begin
      a_nxt.mfix = (rsh > 13'sd60) ? 72'd0 : (72'(mr[23:0]) >> rsh);
      a_nxt.lost = (rsh > 13'sd47) ? (mr[23:0] != 24'd0) :
                   ((48'(mr[23:0]) << (48 - rsh)) != 48'd0);
    end else a_nxt.mfix = 72'(mr[23:0]) << (-rsh);
  end

  always_ff @(posedge clk) begin
    if (en) a_r <= a_nxt;
  end

  always_comb begin
    // s = p +/- 0.5, in magnitude: pos -> m+0.5, neg/zero -> m+0.5 too
    half = 72'd1 << (FRAC - 1);
    sum = a_r.mfix + half;
    // single rounding of the sum: keep 24 significant bits
    w = sum;
    sh = 13'sd0;
    for (int i = 0; i < 72; i++) if (sum[i]) sh = 13'(i) - 13'sd23;
    rem = 72'd0;
    if (sh > 0) begin
      rem = sum & ((72'd1 << sh) - 72'd1);
      w = sum >> sh;
      // sticky from lost bits below fixed-point precision
      if (rem > (72'd1 << (sh - 1)) || ((rem == (72'd1 << (sh - 1))) && a_r.lost) ||
          ((rem == (72'd1 << (sh - 1))) && !a_r.lost && w[0]))
        w = w + 72'd1;
      w = w << sh;
    end
    mag = (w[71:FRAC] > 72'd255) ? 10'd255 : 10'(w[71:FRAC]);
    q = 8'sd0;
    if (a_r.nan) q = 8'sd0;
    else if (!a_r.sign && !a_r.zero) begin
      q = (a_r.ovf || mag >= 10'd127) ? 8'sd127 : 8'(mag);
    end else begin
      q = (a_r.ovf || mag >= 10'd128) ? -8'sd128 : -8'(mag);
    end
    if (a_r.zero && !a_r.big) q = 8'sd0;
  end
endmodule
`default_nettype wire

[hw/rtl/float_to_int8_quantizer.sv]
// Pipeline: multiply, align and round registers lie between input transaction and result.
// Throughput: one item per cycle unless the output stalls; all lanes run side by side, one multiplier each.
// Stall: the output register holds while out.ready is low; a full pipe stops input.
// Reset: rst_n synchronous active low clears valids and sets scale to 1.0.
// ----------------------------------------------------------------------------
// float_to_int8_quantizer
// Lane-parallel float32 to int8 quantizer with valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "float_to_int8_quantizer_defines.svh"
module float_to_int8_quantizer #(
  parameter int LANES = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  f2i_in_if.sink   in_ch,
  f2i_out_if.source out_ch,
  f2i_cfg_if.sink  cfg_ch
);
  import f2i_pkg::*;
  localparam int NL = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

  fp32_t scale_r;
  logic v1_r, v2_r, v3_r;
  prod_t p_r [FIELD_LANES];
  cnt_t c1_r, c2_r, c3_r;
  q8_t q3_r [FIELD_LANES];
  prod_t p_nxt [FIELD_LANES];
  q8_t q_nxt [FIELD_LANES];
  fp32_t lanes [FIELD_LANES];
  cnt_t cnt;
  logic adv3, adv2, adv1;
  logic a_en;

  assign cfg_ch.ready = 1'b1;
  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign a_en = adv2 && v1_r;
  assign in_ch.ready = adv1;
  assign lanes[0] = in_ch.lane_a;
  assign lanes[1] = in_ch.lane_b;
  assign lanes[2] = in_ch.lane_c;
  assign lanes[3] = in_ch.lane_d;
  assign cnt = (in_ch.lane_count > 3'(NL)) ? 3'(NL) : in_ch.lane_count;

  for (genvar k = 0; k < FIELD_LANES; k++) begin : g_lane
    f2i_mul u_mul (.x(1'b1), .xv(lanes[k]), .sv(scale_r), .p(p_nxt[k]));
    f2i_round u_rnd (.clk(clk), .en(a_en), .p(p_r[k]), .q(q_nxt[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) scale_r <= cfg_ch.data;
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // merge: unused lanes forced to zero
  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      c1_r <= cnt;
      p_r <= p_nxt;
    end
    if (a_en) c2_r <= c1_r;
    if (adv3 && v2_r) begin
      c3_r <= c2_r;
      for (int k = 0; k < FIELD_LANES; k++)
        q3_r[k] <= (3'(k) < c2_r) ? q_nxt[k] : 8'sd0;
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.byte_a = q3_r[0];
  assign out_ch.byte_b = q3_r[1];
  assign out_ch.byte_c = q3_r[2];
  assign out_ch.byte_d = q3_r[3];
  assign out_ch.valid_count = c3_r;

  `F2I_ASSERT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result lost")
  `F2I_ASSERT(a_cnt, clk, rst_n, out_ch.valid |-> out_ch.valid_count <= 3'(NL), "bad count")
  `F2I_ASSERT(a_rdy, clk, rst_n, !out_ch.valid |-> in_ch.ready, "needless stall")
  `F2I_ASSERT_NR(a_rst, clk, !rst_n |=> !out_ch.valid, "valid after reset")
endmodule
`default_nettype wire
